/* rtl/wbba_pkg.sv */
package wbba_pkg;

  // Sizing of the slot table and the running total.
  localparam int NUM_SLOTS  = 16;
  localparam int USAGE_BITS = 48;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LIMIT_W    = 52;
  localparam int TOTAL_W    = USAGE_BITS + SLOT_W;
  localparam int SUM_W      = (TOTAL_W > LIMIT_W) ? TOTAL_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(268435456);
  localparam logic [SUM_W-1:0]   TOTAL_CAP   = SUM_W'({LIMIT_W{1'b1}});

  // Request codes.
  localparam logic [1:0] REQ_REGISTER   = 2'd0;
  localparam logic [1:0] REQ_UNREGISTER = 2'd1;
  localparam logic [1:0] REQ_WRITE_DONE = 2'd2;
  localparam logic [1:0] REQ_FLUSH_RPT  = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FLUSH_REQ = 2'd1;
  localparam logic [1:0] STAT_NO_RELIEF = 2'd2;
  localparam logic [1:0] STAT_FLUSH_ERR = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  writer_slot;
    logic [47:0] usage_bytes;
    logic        flush_ok;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         flush_target;
    logic [LIMIT_W-1:0] total_bytes;
  } out_word_t;

endpackage

/* rtl/write_buffer_budget_arbiter.sv */
// Write-buffer memory budget arbiter.
//
// Requests arrive on the in_ channel (valid/stall); one result word leaves on
// the out_ channel for every request word. A word moves at a clock edge where
// valid is high and stall is low. The memory limit is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this. Each request is worked off
// by a small sequencer around one shared add/subtract unit and a slot table
// with registered read. An unregister passes the read and subtract steps; a
// register adds the add step, a write-completed request then the limit check,
// and a flush report a progress check before the limit check. If the total
// reaches the limit, the whole slot table is scanned, one slot read per cycle.
// Ignored requests and failed flushes go straight to the result. in_stall is
// high while a request is in progress, so the next word is taken in the cycle
// after a result is loaded. The result sits in an output register, so that
// next request is taken while the receiver stalls; the sequencer only waits
// at its end if the previous result has still not been taken. Reset
// (synchronous, rst_n low) empties the slot table, clears the total and any
// flush episode, and restores the limit to 256 MiB. No clearing pass is needed.
module write_buffer_budget_arbiter
  import wbba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_SUB   = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_PROG  = 4'd4;
  localparam logic [3:0] S_LIM   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  logic [3:0]            state_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic [SUM_W-1:0]      total_r;
  logic [NUM_SLOTS-1:0]  present_r;
  logic [NUM_SLOTS-1:0]  np_mask_r;
  logic                  pend_r;
  logic [SLOT_W-1:0]     pend_slot_r;
  logic [USAGE_BITS-1:0] ubf_r;
  logic                  out_valid_r;

  // Working registers of the request in progress.
  logic [1:0]            req_r;
  logic [SLOT_W-1:0]     tgt_r;
  logic [USAGE_BITS-1:0] use_r;
  logic [1:0]            status_r;
  logic [SLOT_W-1:0]     target_r;
  logic [SLOT_W-1:0]     scan_idx_r;
  logic [SLOT_W-1:0]     cmp_idx_r;
  logic                  cmp_vld_r;
  logic                  found_r;
  logic [SLOT_W-1:0]     best_idx_r;
  logic [USAGE_BITS-1:0] best_use_r;
  out_word_t             out_data_r;

  logic                  in_acc;
  logic                  res_free;
  logic                  slot_ok;
  logic [SLOT_W-1:0]     in_slot;
  logic [SLOT_W-1:0]     raddr;
  logic [USAGE_BITS-1:0] rdata;
  logic [USAGE_BITS-1:0] old_use;
  logic                  ram_we;
  logic [SUM_W-1:0]      alu_a;
  logic [SUM_W-1:0]      alu_b;
  logic                  alu_sub;
  logic [SUM_W-1:0]      alu_res;
  logic                  alu_carry;
  logic                  cand_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign res_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign slot_ok = (32'(in_data.writer_slot) < NUM_SLOTS);
  assign in_slot = SLOT_W'(in_data.writer_slot);

  // The slot table is read at the request's slot, or walked during a scan.
  assign raddr   = (state_r == S_SCAN) ? scan_idx_r : tgt_r;
  assign ram_we  = (state_r == S_ADD);
  assign old_use = present_r[tgt_r] ? rdata : '0;

  wbba_ram #(
    .WIDTH(USAGE_BITS),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tgt_r),
    .wdata(use_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Operand selection for the shared adder. The scan compare owns the unit
  // whenever a scan read is returning; no other step runs in those cycles.
  always_comb begin
    alu_a   = total_r;
    alu_b   = SUM_W'(old_use);
    alu_sub = 1'b1;
    if (cmp_vld_r) begin
      alu_a = SUM_W'(best_use_r);
      alu_b = SUM_W'(rdata);
    end else begin
      case (state_r)
        S_ADD: begin
          alu_b   = SUM_W'(use_r);
          alu_sub = 1'b0;
        end
        S_PROG: begin
          alu_a = SUM_W'(use_r);
          alu_b = SUM_W'(ubf_r);
        end
        S_LIM: begin
          alu_b = SUM_W'(limit_r);
        end
        default: begin
          alu_b = SUM_W'(old_use);
        end
      endcase
    end
  end

  wbba_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .res  (alu_res),
    .carry(alu_carry)
  );

  // A scanned slot becomes the candidate when it is present, has made
  // progress, and holds strictly more than the best so far. Strictness keeps
  // the lowest index on ties and skips empty slots.
  assign cand_ok = present_r[cmp_idx_r] && !np_mask_r[cmp_idx_r] && !alu_carry;

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RESET;
      total_r     <= '0;
      present_r   <= '0;
      np_mask_r   <= '0;
      pend_r      <= 1'b0;
      pend_slot_r <= '0;
      ubf_r       <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      cmp_vld_r <= (state_r == S_SCAN);
      // A new result is loaded as soon as the output register is free;
      // otherwise a taken result leaves it empty.
      if (state_r == S_DONE && res_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.req_type == REQ_FLUSH_RPT) begin
              if (!pend_r) begin
                state_r <= S_DONE;
              end else if (!in_data.flush_ok) begin
                pend_r    <= 1'b0;
                np_mask_r <= '0;
                state_r   <= S_DONE;
              end else begin
                state_r <= S_RD;
              end
            end else if (!slot_ok) begin
              state_r <= S_DONE;
            end else if (in_data.req_type == REQ_UNREGISTER && !present_r[in_slot]) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          state_r <= S_SUB;
        end
        S_SUB: begin
          total_r <= alu_res;
          if (req_r == REQ_UNREGISTER) begin
            present_r[tgt_r] <= 1'b0;
            np_mask_r[tgt_r] <= 1'b0;
            if (pend_r && pend_slot_r == tgt_r) begin
              pend_r <= 1'b0;
            end
            state_r <= S_DONE;
          end else begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          total_r          <= alu_res;
          present_r[tgt_r] <= 1'b1;
          if (req_r == REQ_REGISTER) begin
            state_r <= S_DONE;
          end else if (req_r == REQ_WRITE_DONE) begin
            np_mask_r <= '0;
            pend_r    <= 1'b0;
            state_r   <= S_LIM;
          end else begin
            state_r <= S_PROG;
          end
        end
        S_PROG: begin
          // Usage that did not fall marks the slot as making no progress.
          np_mask_r[tgt_r] <= alu_carry;
          state_r          <= S_LIM;
        end
        S_LIM: begin
          if (!alu_carry) begin
            pend_r    <= 1'b0;
            np_mask_r <= '0;
            state_r   <= S_DONE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_idx_r == LAST_SLOT) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!found_r) begin
            pend_r    <= 1'b0;
            np_mask_r <= '0;
          end else begin
            pend_r      <= 1'b1;
            pend_slot_r <= best_idx_r;
            ubf_r       <= best_use_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= in_data.req_type;
      use_r    <= USAGE_BITS'(in_data.usage_bytes);
      tgt_r    <= (in_data.req_type == REQ_FLUSH_RPT) ? pend_slot_r : in_slot;
      target_r <= '0;
      status_r <= (in_data.req_type == REQ_FLUSH_RPT && pend_r && !in_data.flush_ok) ?
                  STAT_FLUSH_ERR : STAT_OK;
    end
    if (state_r == S_LIM) begin
      scan_idx_r <= '0;
      found_r    <= 1'b0;
      best_idx_r <= '0;
      best_use_r <= '0;
    end
    if (state_r == S_SCAN) begin
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
      cmp_idx_r  <= scan_idx_r;
    end
    if (cmp_vld_r && cand_ok) begin
      best_use_r <= rdata;
      best_idx_r <= cmp_idx_r;
      found_r    <= 1'b1;
    end
    if (state_r == S_FIN) begin
      if (found_r) begin
        status_r <= STAT_FLUSH_REQ;
        target_r <= best_idx_r;
      end else begin
        status_r <= STAT_NO_RELIEF;
      end
    end
    if (state_r == S_DONE && res_free) begin
      out_data_r.status       <= status_r;
      out_data_r.flush_target <= (status_r == STAT_FLUSH_REQ) ? 4'(target_r) : 4'd0;
      out_data_r.total_bytes  <= (total_r > TOTAL_CAP) ? LIMIT_W'(TOTAL_CAP) :
                                 LIMIT_W'(total_r);
    end
  end

endmodule

/* rtl/wbba_ram.sv */
module wbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/wbba_alu.sv */
module wbba_alu
  import wbba_pkg::*;
(
  input  logic [SUM_W-1:0] a,
  input  logic [SUM_W-1:0] b,
  input  logic             sub,
  output logic [SUM_W-1:0] res,
  output logic             carry
);

  // On a subtraction the carry out is set when a is at least b.
  logic [SUM_W:0] full;

  assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{SUM_W{1'b0}}, sub};
  assign res   = full[SUM_W-1:0];
  assign carry = full[SUM_W];

endmodule
